// ----- rtl/core/skt_pkg.sv -----
// Shared types, codes and defaults for the sorted keyed table.
package skt_pkg;

  localparam int DEF_DEPTH     = 16;
  localparam int DEF_KEY_BYTES = 8;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } skt_action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [15:0] volume;
    logic [19:0] price;
    logic [3:0]  position;
  } skt_in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] entry_key;
    logic [15:0] entry_volume;
    logic [19:0] entry_price;
    logic [4:0]  count;
    logic        full_res;
    logic        empty_res;
  } skt_out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] volume;
    logic [19:0] price;
  } skt_entry_t;

endpackage

// ----- rtl/core/skt_mem.sv -----
// Entry storage: one write port and one registered read port.
module skt_mem
  import skt_pkg::*;
#(
  parameter int DEPTH = DEF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  skt_entry_t               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output skt_entry_t               rdata
);

  skt_entry_t mem [DEPTH];
  skt_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/skt_seq.sv -----
// Sequencer that searches and shifts the table one slot at a time through a shared key compare.
module skt_seq
  import skt_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  skt_in_t                  in_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output skt_out_t                 res_data,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output skt_entry_t               mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  skt_entry_t               mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;
  localparam logic [63:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (KEY_BYTES * 8)) - 64'd1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS_RD  = 11'b000_0000_0010,
    S_INS_CMP = 11'b000_0000_0100,
    S_INS_PUT = 11'b000_0000_1000,
    S_RM_RD   = 11'b000_0001_0000,
    S_RM_CMP  = 11'b000_0010_0000,
    S_SH_RD   = 11'b000_0100_0000,
    S_SH_WR   = 11'b000_1000_0000,
    S_RD_RD   = 11'b001_0000_0000,
    S_RD_CAP  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } skt_state_t;

  skt_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ok_r, ok_nxt;
  skt_entry_t    new_r, new_nxt;
  skt_entry_t    rent_r, rent_nxt;

  logic [CW-1:0] idx_ext;
  logic          key_gt;
  logic          key_eq;
  logic          key_lt;

  assign idx_ext = CW'(idx_r);
  assign key_gt  = mem_rdata.key > new_r.key;
  assign key_eq  = mem_rdata.key == new_r.key;
  assign key_lt  = !key_gt && !key_eq;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = ok_r;
    new_nxt   = new_r;
    rent_nxt  = rent_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.key    = in_data.key & KEY_MASK;
          new_nxt.volume = in_data.volume;
          new_nxt.price  = in_data.price;
          rent_nxt       = '0;
          ok_nxt         = 1'b0;
          state_nxt      = S_DONE;
          unique case (skt_action_t'(in_data.action))
            ACT_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                state_nxt = S_DONE;
              end else if (cnt_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_INS_PUT;
              end else begin
                idx_nxt   = AW'(cnt_r - CW'(1));
                state_nxt = S_INS_RD;
              end
            end
            ACT_REMOVE: begin
              if (cnt_r != '0) begin
                idx_nxt   = '0;
                state_nxt = S_RM_RD;
              end
            end
            ACT_READ: begin
              if (PW'(in_data.position) < PW'(cnt_r)) begin
                idx_nxt   = AW'(in_data.position);
                state_nxt = S_RD_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (key_gt) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r + AW'(1);
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = new_r;
        cnt_nxt   = cnt_r + CW'(1);
        ok_nxt    = 1'b1;
        state_nxt = S_DONE;
      end
      S_RM_RD: begin
        state_nxt = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (key_eq) begin
          if (idx_ext + CW'(1) < cnt_r) begin
            state_nxt = S_SH_RD;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            ok_nxt    = 1'b1;
            state_nxt = S_DONE;
          end
        end else if (key_lt && (idx_ext + CW'(1) < cnt_r)) begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_RM_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD: begin
        mem_raddr = idx_r + AW'(1);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + AW'(1);
        if (idx_ext + CW'(2) < cnt_r) begin
          state_nxt = S_SH_RD;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RD_RD: begin
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        rent_nxt  = mem_rdata;
        ok_nxt    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r  <= idx_nxt;
    ok_r   <= ok_nxt;
    new_r  <= new_nxt;
    rent_r <= rent_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res_data              = '0;
    res_data.ok           = ok_r;
    res_data.entry_key    = rent_r.key;
    res_data.entry_volume = rent_r.volume;
    res_data.entry_price  = rent_r.price;
    res_data.count        = 5'(cnt_r);
    res_data.full_res     = (cnt_r == CW'(DEPTH));
    res_data.empty_res    = (cnt_r == '0);
  end

endmodule

// ----- rtl/core/sorted_keyed_table.sv -----
// Insert shifts entries above the new key up a slot and writes the new entry; remove searches
// from slot 0 and shifts the rest down; read fetches a slot. Results pass the output register.
// One word is handled at a time; the single read port of the entry memory paces the search.
// A new word is taken while the previous result waits in the output register.
// Reset clears the entry count and control; entry memory contents are not cleared.
// Top level of the sorted keyed table.
module sorted_keyed_table
  import skt_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  skt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output skt_out_t out_data
);

  localparam int AW = $clog2(DEPTH);

  logic          res_valid;
  logic          res_ready;
  skt_out_t      res_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  skt_entry_t    mem_wdata;
  logic [AW-1:0] mem_raddr;
  skt_entry_t    mem_rdata;

  logic     out_valid_r, out_valid_nxt;
  skt_out_t out_data_r, out_data_nxt;

  skt_seq #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  skt_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
